FILE: rtl/golomb_gap_list_decoder_top_macros.svh
// Assertion macros for the Golomb gap list decoder.
// Included by the top level; the assertions use the top level's clk and rst_n.
`ifndef GOLOMB_GAP_LIST_DECODER_TOP_MACROS_SVH
`define GOLOMB_GAP_LIST_DECODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define GLD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gap list decoder: same-cycle check failed");
`define GLD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gap list decoder: next-cycle check failed");
`else
`define GLD_ASSERT_SAME(label, ante, cons)
`define GLD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/gld_pkg.sv
// Shared types, constants and helper functions of the Golomb gap list decoder.
// No dependencies; used by every module of the block.
package gld_pkg;

    localparam int DOC_W   = 32;
    localparam int DIV_W   = 31;
    localparam int CNT_W   = 32;
    localparam int RWID_W  = 5;
    localparam int ACC_W   = 33;
    localparam int CFG_IDX_W = 1;

    // Accumulator value that already lies beyond the largest document number.
    localparam logic [ACC_W-1:0] ACC_CAP = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GOLOMB_DIVISOR = 1'b0,
        REG_ENTRY_COUNT    = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_QUOT  = 2'd0,
        PH_REM   = 2'd1,
        PH_EXTRA = 2'd2
    } phase_t;

    typedef struct packed {
        logic             code_bit;
        logic             skip_enable;
        logic [DOC_W-1:0] skip_target;
    } in_item_t;

    typedef struct packed {
        logic [DOC_W-1:0] doc_number;
        logic             selected;
        logic             last_entry;
        logic             overflow;
    } out_item_t;

    typedef struct packed {
        logic [DIV_W-1:0]  divisor;
        logic [RWID_W-1:0] rem_width;
        logic [DOC_W-1:0]  code_limit;
        logic [CNT_W-1:0]  count;
        logic              div_le1;
        logic              restart;
    } gld_cfg_t;

    // Number of bits n with 2^n >= b, taken as the bit length of b-1.
    function automatic logic [RWID_W-1:0] rem_width_of(input logic [DIV_W-1:0] b);
        logic [DIV_W-1:0]  v;
        logic [RWID_W-1:0] w;
        v = b - DIV_W'(1);
        w = '0;
        for (int i = 0; i < DIV_W; i++) begin
            if (v[i])
            begin
                w = RWID_W'(i + 1);
            end
        end
        if (b == '0)
        begin
            w = '0;
        end
        return w;
    endfunction

    // Threshold g = 2^n - b for the truncated-binary remainder.
    function automatic logic [DOC_W-1:0] code_limit_of(input logic [DIV_W-1:0] b,
                                                       input logic [RWID_W-1:0] w);
        logic [DOC_W-1:0] pw;
        pw = DOC_W'(1) << w;
        return pw - {1'b0, b};
    endfunction

endpackage

FILE: rtl/golomb_gap_list_decoder_top.sv
// Golomb gap list decoder, top level: input register, configuration and decode core.
// Depends on gld_pkg, gld_cfg, gld_core and golomb_gap_list_decoder_top_macros.svh.
//
// Usage:
// The input channel (in_valid, in_stall, in_data) carries one code bit per item
// together with the skip filter settings that apply if that bit ends a code.
// The output channel (out_valid, out_stall, out_data) carries one item for every
// finished code: the document number, the filter decision, the last-entry flag
// and the overflow flag. Bits that do not end a code give no output item.
// After an input item is accepted, it passes the input register and then the decode
// step that loads the result register, where out_valid rises.
// Throughput is one code bit per cycle while no held result stalls the input; the
// decode step lies between the input register and the result register.
// A write on the configuration port restarts the list; the new settings take
// effect in the cycle after the write. After reset the divisor is one and the
// entry count zero, so every bit is dropped until the count is written.
// When the receiver stalls, the result register holds its item; in_stall rises
// only while an item waits in the input register behind a held result.
`include "golomb_gap_list_decoder_top_macros.svh"
module golomb_gap_list_decoder_top
    import gld_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DOC_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data
);

    gld_cfg_t cfg;
    logic     in_valid_reg;
    in_item_t in_reg;
    logic     advance;
    logic     take;

    assign in_stall = in_valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_reg <= in_data;
        end
    end

    gld_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gld_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (in_valid_reg),
        .item       (in_reg),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    // A saturated document number is always the largest one.
    `GLD_ASSERT_SAME(a_ovf_saturates, out_valid && out_data.overflow, out_data.doc_number == '1)
    // The input side only stalls behind a result that the receiver is holding.
    `GLD_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall)
    // An accepted item always lands in the input register.
    `GLD_ASSERT_NEXT(a_take_loads, in_valid && !in_stall, in_valid_reg)

endmodule

FILE: rtl/gld_cfg.sv
// Configuration registers of the Golomb gap list decoder, with the derived
// remainder width and short-code threshold. Depends on gld_pkg.
module gld_cfg
    import gld_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DOC_W-1:0]     cfg_data,
    output gld_cfg_t             cfg
);

    logic [DIV_W-1:0]  divisor_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [RWID_W-1:0] width_reg;
    logic [DOC_W-1:0]  limit_reg;
    logic              le1_reg;
    logic              restart_reg;

    logic [DIV_W-1:0]  div_wr;
    logic [RWID_W-1:0] width_wr;

    assign div_wr   = cfg_data[DIV_W-1:0];
    assign width_wr = rem_width_of(div_wr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisor_reg <= DIV_W'(1);
            count_reg   <= '0;
            width_reg   <= '0;
            limit_reg   <= '0;
            le1_reg     <= 1'b1;
            restart_reg <= 1'b0;
        end
        else
        begin
            restart_reg <= cfg_we;
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    REG_GOLOMB_DIVISOR:
                    begin
                        divisor_reg <= div_wr;
                        width_reg   <= width_wr;
                        limit_reg   <= code_limit_of(div_wr, width_wr);
                        le1_reg     <= (div_wr <= DIV_W'(1));
                    end
                    default:
                    begin
                        count_reg <= cfg_data[CNT_W-1:0];
                    end
                endcase
            end
        end
    end

    assign cfg.divisor    = divisor_reg;
    assign cfg.rem_width  = width_reg;
    assign cfg.code_limit = limit_reg;
    assign cfg.count      = count_reg;
    assign cfg.div_le1    = le1_reg;
    assign cfg.restart    = restart_reg;

endmodule

FILE: rtl/gld_core.sv
// Decode state of the Golomb gap list decoder: one code bit per cycle unless a held
// result stalls it, the running document number and the result register. Depends on gld_pkg.
module gld_core
    import gld_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  gld_cfg_t  cfg,
    input  logic      item_valid,
    input  in_item_t  item,
    output logic      advance,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    phase_t            phase_reg, phase_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [DOC_W-1:0]  rem_reg, rem_next;
    logic [RWID_W-1:0] seen_reg, seen_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic              res_valid_reg;
    out_item_t         res_reg;

    logic              fire;
    logic              active;
    logic              bit_in;
    logic [DOC_W-1:0]  rem_shift;
    logic [RWID_W-1:0] seen_inc;
    logic              last_rem_bit;
    logic              rem_ge;
    logic              finish;
    logic [DOC_W-1:0]  op;
    logic              cin;
    logic [ACC_W:0]    sum;
    logic [ACC_W:0]    sum_p1;
    logic [ACC_W:0]    qsum;
    logic              ovf;
    logic [DOC_W-1:0]  val;
    out_item_t         result;

    assign advance = !res_valid_reg || !out_stall;
    assign fire    = item_valid && advance;
    assign active  = (remain_reg != '0);
    assign bit_in  = item.code_bit;

    assign rem_shift    = {rem_reg[DOC_W-2:0], bit_in};
    assign seen_inc     = seen_reg + RWID_W'(1);
    assign last_rem_bit = ({1'b0, seen_inc} + (RWID_W+1)'(1)) >= {1'b0, cfg.rem_width};
    assign rem_ge       = (rem_shift >= cfg.code_limit);

    always_comb
    begin
        phase_next = phase_reg;
        if (cfg.restart)
        begin
            phase_next = PH_QUOT;
        end
        else if (fire && active)
        begin
            case (phase_reg)
                PH_QUOT:
                begin
                    if (!bit_in && !cfg.div_le1)
                    begin
                        phase_next = (cfg.rem_width > RWID_W'(1)) ? PH_REM : PH_EXTRA;
                    end
                end
                PH_REM:
                begin
                    if (last_rem_bit)
                    begin
                        phase_next = rem_ge ? PH_EXTRA : PH_QUOT;
                    end
                end
                default:
                begin
                    phase_next = PH_QUOT;
                end
            endcase
        end
    end

    always_comb
    begin
        finish = 1'b0;
        op     = '0;
        cin    = 1'b0;
        case (phase_reg)
            PH_QUOT:
            begin
                finish = !bit_in && cfg.div_le1;
            end
            PH_REM:
            begin
                finish = last_rem_bit && !rem_ge;
                op     = rem_shift;
            end
            PH_EXTRA:
            begin
                // The stored value is already twice the partial remainder less g.
                finish = 1'b1;
                op     = rem_reg;
                cin    = bit_in;
            end
            default:
            begin
                finish = 1'b0;
            end
        endcase
    end

    // The accumulator holds the running value plus one plus the quotient part.
    assign sum    = {1'b0, acc_reg} + {2'b00, op} + {{ACC_W{1'b0}}, cin};
    assign sum_p1 = {1'b0, acc_reg} + {2'b00, op} + (ACC_W+1)'(cin ? 2 : 1);
    assign ovf    = |sum[ACC_W:DOC_W];
    assign val    = ovf ? '1 : sum[DOC_W-1:0];
    assign qsum   = {1'b0, acc_reg} + {3'b000, cfg.divisor};

    always_comb
    begin
        result.doc_number = val;
        result.selected   = !item.skip_enable || (val == '0) || (val > item.skip_target);
        result.last_entry = (remain_reg == CNT_W'(1));
        result.overflow   = ovf;
    end

    always_comb
    begin
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        seen_next   = seen_reg;
        remain_next = remain_reg;
        if (cfg.restart)
        begin
            acc_next    = '0;
            rem_next    = '0;
            seen_next   = '0;
            remain_next = cfg.count;
        end
        else if (fire && active)
        begin
            if (phase_reg == PH_QUOT)
            begin
                rem_next  = '0;
                seen_next = '0;
                if (bit_in)
                begin
                    acc_next = (qsum > {1'b0, ACC_CAP}) ? ACC_CAP : qsum[ACC_W-1:0];
                end
            end
            else if (phase_reg == PH_REM)
            begin
                seen_next = seen_inc;
                rem_next  = rem_shift;
                if (last_rem_bit && rem_ge)
                begin
                    rem_next = {rem_shift[DOC_W-2:0], 1'b0} - cfg.code_limit;
                end
            end
            if (finish)
            begin
                acc_next    = ovf ? ACC_CAP : sum_p1[ACC_W-1:0];
                rem_next    = '0;
                seen_next   = '0;
                remain_next = remain_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_QUOT;
            acc_reg       <= '0;
            rem_reg       <= '0;
            seen_reg      <= '0;
            remain_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            rem_reg    <= rem_next;
            seen_reg   <= seen_next;
            remain_reg <= remain_next;
            if (fire && active && finish && !cfg.restart)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && active && finish)
        begin
            res_reg <= result;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

endmodule

FILE: tb/sv/gld_doc_checker.sv
`timescale 1ns / 100ps
// Output checker for the Golomb gap list decoder: follows register writes and accepted
// code bits, predicts each decoded document number and compares it with the output item.
// Depends on gld_pkg.
module gld_doc_checker
    import gld_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DOC_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  in_item_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  out_item_t            out_data,
    output int                   fail_count,
    output int                   pending,
    output int                   live_items
);

    localparam logic [63:0] QUOT_CAP = 64'h1_FFFF_FFFF;
    localparam logic [63:0] DOC_CAP  = 64'hFFFF_FFFF;

    logic [63:0] divisor;
    logic [63:0] list_len;
    logic [63:0] quot_acc;
    logic [63:0] rem_acc;
    logic [63:0] short_limit;
    logic [63:0] next_doc;
    logic [63:0] codes_done;
    int unsigned rem_seen;
    int unsigned rem_bits;
    phase_t      phase;
    out_item_t   doc_expect_q[$];

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        if (fail_count < 40)
        begin
            $display("%0t decoder check: %s: got %0h, expected %0h", $time, what, got, want);
        end
        fail_count++;
    endtask

    // A register write recomputes the remainder width and threshold and starts a new list.
    task automatic restart_list();
        logic [63:0] pw;
        pw = 64'd1;
        rem_bits = 0;
        while (pw < divisor)
        begin
            rem_bits++;
            pw = pw << 1;
        end
        short_limit = pw - divisor;
        phase = PH_QUOT;
        quot_acc = '0;
        rem_acc = '0;
        rem_seen = 0;
        next_doc = '0;
        codes_done = '0;
    endtask

    task automatic finish_code(input logic [63:0] r, input in_item_t it);
        logic [63:0] val;
        out_item_t   res;
        val = next_doc + r + quot_acc;
        res.overflow = (val > DOC_CAP);
        if (res.overflow)
        begin
            val = DOC_CAP;
        end
        codes_done++;
        res.doc_number = val[31:0];
        res.selected = (val > {32'd0, it.skip_target}) || (val == 0) || !it.skip_enable;
        res.last_entry = (codes_done == list_len);
        doc_expect_q = {doc_expect_q, res};
        next_doc = val + 1;
        phase = PH_QUOT;
        quot_acc = '0;
        rem_acc = '0;
        rem_seen = 0;
    endtask

    task automatic decode_bit(input in_item_t it);
        live_items++;
        if (codes_done >= list_len)
        begin
            return;
        end
        case (phase)
            PH_QUOT:
            begin
                if (it.code_bit)
                begin
                    quot_acc = quot_acc + divisor;
                    if (quot_acc > QUOT_CAP)
                    begin
                        quot_acc = QUOT_CAP;
                    end
                end
                else if (divisor <= 1)
                begin
                    finish_code('0, it);
                end
                else
                begin
                    rem_acc = '0;
                    rem_seen = 0;
                    if (rem_bits > 1)
                    begin
                        phase = PH_REM;
                    end
                    else if (rem_acc >= short_limit)
                    begin
                        phase = PH_EXTRA;
                    end
                    else
                    begin
                        finish_code('0, it);
                    end
                end
            end
            PH_REM:
            begin
                rem_acc = ((rem_acc << 1) | 64'(it.code_bit)) & DOC_CAP;
                rem_seen++;
                if (rem_seen + 1 >= rem_bits)
                begin
                    if (rem_acc >= short_limit)
                    begin
                        phase = PH_EXTRA;
                    end
                    else
                    begin
                        finish_code(rem_acc, it);
                    end
                end
            end
            default:
            begin
                // The extra bit lifts the value into the long codes; the threshold comes off.
                rem_acc = ((rem_acc << 1) | 64'(it.code_bit)) & DOC_CAP;
                if (rem_acc >= short_limit)
                begin
                    rem_acc = rem_acc - short_limit;
                end
                else
                begin
                    rem_acc = '0;
                end
                finish_code(rem_acc, it);
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            divisor = 64'd1;
            list_len = '0;
            restart_list();
            doc_expect_q.delete();
            fail_count = 0;
            live_items = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (doc_expect_q.size() == 0)
                begin
                    report("item with nothing expected", 64'(out_data.doc_number), '0);
                end
                else
                begin
                    want = doc_expect_q.pop_front();
                    if (out_data.doc_number !== want.doc_number)
                    begin
                        report("doc_number", 64'(out_data.doc_number), 64'(want.doc_number));
                    end
                    if (out_data.selected !== want.selected)
                    begin
                        report("selected", 64'(out_data.selected), 64'(want.selected));
                    end
                    if (out_data.last_entry !== want.last_entry)
                    begin
                        report("last_entry", 64'(out_data.last_entry), 64'(want.last_entry));
                    end
                    if (out_data.overflow !== want.overflow)
                    begin
                        report("overflow", 64'(out_data.overflow), 64'(want.overflow));
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_idx_t'(cfg_index) == REG_GOLOMB_DIVISOR)
                begin
                    divisor = 64'(cfg_data[DIV_W-1:0]);
                end
                else
                begin
                    list_len = 64'(cfg_data);
                end
                restart_list();
            end
            if (in_valid && !in_stall)
            begin
                decode_bit(in_data);
            end
            pending = doc_expect_q.size();
        end
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// Top of the Golomb gap list decoder testbench: clock, reset, register writes, coded
// bit streams and receiver stalls. Depends on gld_pkg, gld_doc_checker and the block.
module tb;
    import gld_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LIVE_TARGET    = 1650;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DOC_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_stall;
    out_item_t            out_data;

    int fail_count;
    int pending;
    int live_items;

    logic        tx_gaps;
    logic        rx_idle;
    logic        hold_req;
    logic [63:0] enc_div;
    logic [63:0] enc_g;
    int          enc_n;

    golomb_gap_list_decoder_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    gld_doc_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending),
        .live_items (live_items)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [31:0] pick_target();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 64);
            2: return $urandom_range(0, 4096);
            default: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
        endcase
    endfunction

    // Remainder width and short-code threshold of the divisor, used to encode remainders.
    task automatic set_encoder(input logic [DIV_W-1:0] b);
        logic [63:0] pw;
        pw = 64'd1;
        enc_n = 0;
        enc_div = 64'(b);
        while (pw < enc_div)
        begin
            enc_n++;
            pw = pw << 1;
        end
        enc_g = pw - enc_div;
    endtask

    task automatic put_bit(input logic b, input logic en, input logic [31:0] tgt);
        int       gap;
        int       p;
        in_item_t it;
        gap = 0;
        if (tx_gaps)
        begin
            p = $urandom_range(0, 99);
            if (p >= 95)
            begin
                gap = $urandom_range(8, 40);
            end
            else if (p >= 75)
            begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        it.code_bit = b;
        it.skip_enable = en;
        it.skip_target = tgt;
        in_valid <= 1'b1;
        in_data <= it;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        @(negedge clk);
    endtask

    // Unary quotient, then the truncated-binary remainder: short codes below the threshold,
    // long codes carry the remainder plus the threshold in one more bit.
    task automatic put_code(input int unsigned q, input logic [63:0] r);
        logic [63:0] val;
        int          nb;
        repeat (q) put_bit(1'b1, 1'($urandom_range(0, 1)), pick_target());
        put_bit(1'b0, 1'($urandom_range(0, 1)), pick_target());
        if (enc_div > 1)
        begin
            if (r < enc_g)
            begin
                val = r;
                nb = enc_n - 1;
            end
            else
            begin
                val = r + enc_g;
                nb = enc_n;
            end
            for (int i = nb - 1; i >= 0; i--)
            begin
                put_bit(val[i], 1'($urandom_range(0, 1)), pick_target());
            end
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        drain_results();
        // A bit that ends no code may still sit in the input stage.
        repeat (3) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == REG_GOLOMB_DIVISOR)
        begin
            set_encoder(val[DIV_W-1:0]);
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Receiver: random stall stretches, quiet stretches, and one long hold on request.
    initial
    begin
        int   seg;
        int   hold_left;
        int   p;
        logic st;
        out_stall = 1'b0;
        seg = 0;
        hold_left = 0;
        st = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = 120;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!rx_idle)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                if (seg == 0)
                begin
                    p = $urandom_range(0, 99);
                    if (p < 45)
                    begin
                        st = 1'b0;
                        seg = $urandom_range(1, 6);
                    end
                    else if (p < 80)
                    begin
                        st = 1'b1;
                        seg = $urandom_range(1, 3);
                    end
                    else if (p < 95)
                    begin
                        st = 1'b0;
                        seg = $urandom_range(10, 30);
                    end
                    else
                    begin
                        st = 1'b1;
                        seg = $urandom_range(10, 30);
                    end
                end
                seg--;
                out_stall <= st;
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("[golomb_gap_list_decoder_top] ERROR");
        $finish;
    end

    initial
    begin
        logic [31:0] div_data;
        logic [31:0] cnt_data;
        logic [63:0] rem;
        int unsigned ncodes;
        int unsigned q;
        int          p;
        logic        big_div;
        int          phase_no;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_GOLOMB_DIVISOR;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        tx_gaps = 1'b0;
        rx_idle = 1'b0;
        hold_req = 1'b0;
        set_encoder(DIV_W'(1));
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // After reset the list is empty, so these bits are dropped.
        put_bit(1'b0, 1'b1, 32'h0);
        put_bit(1'b1, 1'b0, 32'hFFFF_FFFF);

        // Divisor zero: quotient bits add nothing and every gap is one. The first value is
        // zero and passes the filter; the bit after the last entry is dropped.
        write_reg(REG_GOLOMB_DIVISOR, 32'd0);
        write_reg(REG_ENTRY_COUNT, 32'd3);
        put_bit(1'b1, 1'b1, 32'hFFFF_FFFF);
        put_bit(1'b0, 1'b1, 32'hFFFF_FFFF);
        put_bit(1'b0, 1'b1, 32'h0);
        put_bit(1'b0, 1'b1, 32'hFFFF_FFFF);
        put_bit(1'b0, 1'b0, 32'h0);

        // Divisor one: the gap is the quotient plus one.
        write_reg(REG_GOLOMB_DIVISOR, 32'd1);
        write_reg(REG_ENTRY_COUNT, 32'd2);
        put_code(2, 64'd0);
        put_code(0, 64'd0);

        // Divisor two: no plain remainder bits, only the extra bit.
        write_reg(REG_GOLOMB_DIVISOR, 32'd2);
        put_code(0, 64'd1);
        put_code(1, 64'd0);

        // Divisor five: one short and one long remainder.
        write_reg(REG_GOLOMB_DIVISOR, 32'd5);
        put_code(0, 64'd2);
        put_code(0, 64'd4);

        phase_no = 0;
        while (live_items < LIVE_TARGET)
        begin
            if (phase_no == 0)
            begin
                // Largest divisor, with the unused top bit of the write data set.
                div_data = 32'hFFFF_FFFF;
                cnt_data = 32'hFFFF_FFFF;
            end
            else if (phase_no == 1)
            begin
                div_data = 32'd1;
                cnt_data = 32'hFFFF_FFFF;
            end
            else
            begin
                p = $urandom_range(0, 99);
                if (p < 5)
                begin
                    div_data = 32'd0;
                end
                else if (p < 20)
                begin
                    div_data = 32'd1;
                end
                else if (p < 30)
                begin
                    div_data = 32'd2;
                end
                else if (p < 60)
                begin
                    div_data = $urandom_range(3, 16);
                end
                else if (p < 80)
                begin
                    div_data = $urandom_range(17, 5000);
                end
                else if (p < 92)
                begin
                    div_data = $urandom_range(1, 32'h7FFF_FFFF);
                end
                else
                begin
                    div_data = 32'h7FFF_FFFF;
                end
                div_data[31] = ($urandom_range(0, 9) == 0);
                p = $urandom_range(0, 99);
                if (p < 5)
                begin
                    cnt_data = 32'd0;
                end
                else if (p < 12)
                begin
                    cnt_data = 32'd1;
                end
                else if (p < 70)
                begin
                    cnt_data = $urandom_range(2, 40);
                end
                else if (p < 85)
                begin
                    cnt_data = $urandom_range(41, 400);
                end
                else if (p < 93)
                begin
                    cnt_data = 32'hFFFF_FFFF;
                end
                else
                begin
                    cnt_data = $urandom;
                end
            end
            if ($urandom_range(0, 1) != 0)
            begin
                write_reg(REG_GOLOMB_DIVISOR, div_data);
                write_reg(REG_ENTRY_COUNT, cnt_data);
            end
            else
            begin
                write_reg(REG_ENTRY_COUNT, cnt_data);
                write_reg(REG_GOLOMB_DIVISOR, div_data);
            end
            big_div = (enc_div > 5000);
            tx_gaps = (phase_no > 1) && ($urandom_range(0, 3) != 0);
            rx_idle = (phase_no == 1) || ($urandom_range(0, 3) != 0);

            if (phase_no == 0)
            begin
                // Enough quotient to saturate its sum, then codes on a saturated value.
                put_code(6, enc_div - 1);
                put_code(0, 64'd0);
                put_code(2, 64'($urandom) % enc_div);
            end
            else
            begin
                ncodes = big_div ? $urandom_range(2, 6) : $urandom_range(10, 60);
                if (phase_no == 1)
                begin
                    // The receiver holds off while bits keep coming, so the block backs up.
                    ncodes = 80;
                    hold_req = 1'b1;
                end
                for (int i = 0; i < ncodes; i++)
                begin
                    p = $urandom_range(0, 99);
                    if (p < 10)
                    begin
                        repeat ($urandom_range(1, 8))
                        begin
                            put_bit(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                    pick_target());
                        end
                    end
                    else
                    begin
                        if (big_div)
                        begin
                            q = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 7)
                                                            : $urandom_range(0, 2);
                        end
                        else
                        begin
                            p = $urandom_range(0, 99);
                            if (p < 70)
                            begin
                                q = $urandom_range(0, 3);
                            end
                            else if (p < 95)
                            begin
                                q = $urandom_range(4, 10);
                            end
                            else
                            begin
                                q = $urandom_range(11, 40);
                            end
                        end
                        p = $urandom_range(0, 99);
                        if (enc_div <= 1 || p < 20)
                        begin
                            rem = 64'd0;
                        end
                        else if (p < 40)
                        begin
                            rem = enc_div - 1;
                        end
                        else
                        begin
                            rem = 64'($urandom) % enc_div;
                        end
                        put_code(q, rem);
                    end
                    if ($urandom_range(0, 99) < 3)
                    begin
                        drain_results();
                    end
                end
            end
            phase_no++;
        end

        drain_results();
        repeat (8) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("[golomb_gap_list_decoder_top] OK");
        end
        else
        begin
            $display("[golomb_gap_list_decoder_top] ERROR");
        end
        $finish;
    end

endmodule
